/* hw/rtl/fpc_pkg.sv */
// Shared types, constants and tables for the face pose classifier.
package fpc_pkg;

  localparam int unsigned COORD_WIDTH     = 16;
  localparam int unsigned ATAN_ITERATIONS = 16;
  localparam int unsigned TAB_LEN         = 24;
  localparam int unsigned FIELD_W         = 16;
  localparam int unsigned NUM_FIELDS      = 12;

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned XW   = CW + 19;  // prescaled CORDIC x/y with growth and sign
  localparam int unsigned ZW   = 26;       // angle accumulator, degrees Q.16
  localparam int unsigned AW   = 17;       // direction, degrees Q9.7
  localparam int unsigned TW   = 18;       // angle difference before wrap
  localparam int unsigned NW   = 16;       // ratio operand magnitude
  localparam int unsigned RW   = 28;       // divider remainder
  localparam int unsigned SW   = 12;       // score, Q4.8
  localparam int unsigned QB   = 12;       // quotient bits
  localparam int unsigned NVEC = 12;
  localparam int unsigned NRAT = 6;

  localparam int signed DEG180    = 23040;
  localparam int signed DEG360    = 46080;
  localparam int signed DEG90_Q16 = 5898240;
  localparam int signed TEN_DEG   = 1280;

  localparam logic [SW-1:0] SCORE_MAX  = 12'd4095;
  localparam logic [SW-1:0] SCORE_TEN  = 12'd2560;
  localparam logic [SW-1:0] UP_LIMIT   = 12'd512;
  localparam logic [SW-1:0] DOWN_LIMIT = 12'd1280;

  localparam logic [SW-1:0] STRONG_RST = 12'd512;
  localparam logic [SW-1:0] WEAK_RST   = 12'd384;
  localparam logic [SW-1:0] SLIGHT_RST = 12'd307;

  // configuration register indexes
  localparam logic [1:0] REG_STRONG = 2'd0;
  localparam logic [1:0] REG_WEAK   = 2'd1;
  localparam logic [1:0] REG_SLIGHT = 2'd2;

  // pose classes
  localparam logic [2:0] POSE_FRONTAL      = 3'd0;
  localparam logic [2:0] POSE_SLIGHT_LEFT  = 3'd1;
  localparam logic [2:0] POSE_SLIGHT_RIGHT = 3'd2;
  localparam logic [2:0] POSE_LEFT         = 3'd3;
  localparam logic [2:0] POSE_RIGHT        = 3'd4;
  localparam logic [2:0] POSE_UP           = 3'd5;
  localparam logic [2:0] POSE_DOWN         = 3'd6;

  // direction special cases
  localparam logic [1:0] SP_NONE = 2'd0;
  localparam logic [1:0] SP_ZERO = 2'd1;
  localparam logic [1:0] SP_180  = 2'd2;

  // vectors: from base landmark to point landmark
  localparam int unsigned VEC_BASE [NVEC] = '{0, 0, 1, 1, 0, 1, 3, 3, 4, 4, 3, 4};
  localparam int unsigned VEC_PT   [NVEC] = '{3, 2, 2, 4, 1, 0, 4, 2, 2, 3, 0, 1};

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           sp;
  } cdc_t;

  typedef struct packed {
    logic [RW-1:0] r;
    logic [NW-1:0] den;
    logic [QB-1:0] q;
    logic          zero;  // numerator <= 0
    logic          full;  // saturated or denominator <= 0
  } div_t;

  typedef struct packed {
    logic g_left;   // theta1 <= 0
    logic g_right;  // theta2 <= 0
    logic g_up;
    logic g_down;
  } grd_t;

  typedef struct packed {
    logic right_in;  // mouth/eye right sum at or left of box centre
    logic left_in;   // mouth/eye left sum at or right of box centre
  } mid_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 26'sd2949120;
      1:  v = 26'sd1740967;
      2:  v = 26'sd919879;
      3:  v = 26'sd466945;
      4:  v = 26'sd234379;
      5:  v = 26'sd117304;
      6:  v = 26'sd58666;
      7:  v = 26'sd29335;
      8:  v = 26'sd14668;
      9:  v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      16: v = 26'sd57;
      17: v = 26'sd29;
      18: v = 26'sd14;
      19: v = 26'sd7;
      20: v = 26'sd4;
      21: v = 26'sd2;
      22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/face_pose_classifier.sv */
// Face pose classifier: landmark stream in, pose class stream out.
//
// Usage:
//   s_axis carries one transaction per face: twelve 16-bit fields packed in
//   s_axis_tdata (eye left x/y, eye right x/y, nose x/y, mouth left x/y,
//   mouth right x/y, box left x, box right x, lowest bits first).
//   m_axis returns one transaction per face with pose_class in tdata[2:0].
//   Thresholds are written through cfg_we_i / cfg_index_i / cfg_wdata_i
//   while the pipeline is empty.
// Timing:
//   Pipeline stages: one input stage, one CORDIC stage per iteration, round,
//   angle difference, divider setup, one divider stage per quotient bit (12)
//   and the output register.
//   Throughput is one transaction per cycle while m_axis_tready does not stall.
// Reset clears all stage valid bits and loads the threshold defaults.
// A stall on m_axis_tready freezes every stage together; s_axis_tready
// drops only while the output holds a result that is not taken.
module face_pose_classifier (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // eye_left_x, eye_left_y, eye_right_x, eye_right_y, nose_x, nose_y,
  // mouth_left_x, mouth_left_y, mouth_right_x, mouth_right_y,
  // box_left_x, box_right_x
  input  logic [fpc_pkg::NUM_FIELDS*fpc_pkg::FIELD_W-1:0] s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // pose_class [2:0], zero fill above
  output logic [7:0]                                 m_axis_tdata,
  input  logic                                       cfg_we_i,
  input  logic [1:0]                                 cfg_index_i,
  input  logic [fpc_pkg::SW-1:0]                     cfg_wdata_i
);
  import fpc_pkg::*;

  localparam int unsigned N     = ATAN_ITERATIONS;
  localparam int unsigned S_LST = N + 15;
  localparam int unsigned NSTG  = N + 17;

  logic adv;
  logic [NSTG-1:0] vld_q;

  assign adv           = !vld_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NSTG-1];

  // configuration
  logic [SW-1:0] strong_q, weak_q, slight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strong_q <= STRONG_RST;
      weak_q   <= WEAK_RST;
      slight_q <= SLIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_STRONG: strong_q <= cfg_wdata_i;
        REG_WEAK:   weak_q   <= cfg_wdata_i;
        REG_SLIGHT: slight_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  // input stage: vectors, special cases, quadrant pre-rotation, box-centre tests
  cdc_t c_q [N+1][NVEC];
  cdc_t c0_d [NVEC];
  mid_t mid_q [S_LST+1];
  mid_t mid0_d;

  always_comb begin
    logic [CW-1:0]        cx [5];
    logic [CW-1:0]        cy [5];
    logic signed [CW:0]   dx, dy;
    logic signed [XW-1:0] px, py;
    logic [CW:0]          sum_l, sum_r, sum_b;
    for (int p = 0; p < 5; p++) begin
      cx[p] = CW'(s_axis_tdata[(2*p)*FIELD_W +: FIELD_W]);
      cy[p] = CW'(s_axis_tdata[(2*p+1)*FIELD_W +: FIELD_W]);
    end
    for (int v = 0; v < NVEC; v++) begin
      dx = $signed({1'b0, cx[VEC_PT[v]]}) - $signed({1'b0, cx[VEC_BASE[v]]});
      dy = $signed({1'b0, cy[VEC_BASE[v]]}) - $signed({1'b0, cy[VEC_PT[v]]});
      px = XW'(dx) <<< 14;
      py = XW'(dy) <<< 14;
      if (dx == '0 && dy == '0) c0_d[v].sp = SP_ZERO;
      else if (dy == '0 && dx < 0) c0_d[v].sp = SP_180;
      else c0_d[v].sp = SP_NONE;
      if (px < 0) begin
        if (py >= 0) begin
          c0_d[v].x = py;
          c0_d[v].y = -px;
          c0_d[v].z = ZW'(DEG90_Q16);
        end else begin
          c0_d[v].x = -py;
          c0_d[v].y = px;
          c0_d[v].z = -ZW'(DEG90_Q16);
        end
      end else begin
        c0_d[v].x = px;
        c0_d[v].y = py;
        c0_d[v].z = '0;
      end
    end
    sum_l = {1'b0, cx[0]} + {1'b0, cx[3]};
    sum_r = {1'b0, cx[1]} + {1'b0, cx[4]};
    sum_b = (CW+1)'(CW'(s_axis_tdata[10*FIELD_W +: FIELD_W]))
          + (CW+1)'(CW'(s_axis_tdata[11*FIELD_W +: FIELD_W]));
    mid0_d.right_in = (sum_r <= sum_b);
    mid0_d.left_in  = (sum_l >= sum_b);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q[0]   <= c0_d;
      mid_q[0] <= mid0_d;
      for (int s = 0; s < S_LST; s++) mid_q[s+1] <= mid_q[s];
    end
  end

  // CORDIC vectoring, one iteration per stage
  for (genvar k = 0; k < N; k++) begin : g_cordic
    cdc_t ck_d [NVEC];
    always_comb begin
      for (int v = 0; v < NVEC; v++) begin
        ck_d[v].sp = c_q[k][v].sp;
        if (c_q[k][v].y > 0) begin
          ck_d[v].x = c_q[k][v].x + (c_q[k][v].y >>> k);
          ck_d[v].y = c_q[k][v].y - (c_q[k][v].x >>> k);
          ck_d[v].z = c_q[k][v].z + atan_q16(k);
        end else begin
          ck_d[v].x = c_q[k][v].x - (c_q[k][v].y >>> k);
          ck_d[v].y = c_q[k][v].y + (c_q[k][v].x >>> k);
          ck_d[v].z = c_q[k][v].z - atan_q16(k);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) c_q[k+1] <= ck_d;
    end
  end

  // round to Q9.7
  logic signed [AW-1:0] ang_q [NVEC];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int v = 0; v < NVEC; v++) begin
        case (c_q[N][v].sp)
          SP_ZERO: ang_q[v] <= '0;
          SP_180:  ang_q[v] <= AW'(DEG180);
          default: ang_q[v] <= AW'((c_q[N][v].z + ZW'(256)) >>> 9);
        endcase
      end
    end
  end

  // angle differences with wrap
  logic signed [TW-1:0] th_q [8];
  always_ff @(posedge clk_i) begin
    logic signed [TW-1:0] d;
    if (adv) begin
      for (int t = 0; t < 8; t++) begin
        case (t)
          0: d = TW'(ang_q[1])  - TW'(ang_q[0]);
          1: d = TW'(ang_q[3])  - TW'(ang_q[2]);
          2: d = TW'(ang_q[4])  - TW'(ang_q[1]);
          3: d = TW'(ang_q[2])  - TW'(ang_q[5]);
          4: d = TW'(ang_q[7])  - TW'(ang_q[6]);
          5: d = TW'(ang_q[9])  - TW'(ang_q[8]);
          6: d = TW'(ang_q[10]) - TW'(ang_q[7]);
          default: d = TW'(ang_q[8]) - TW'(ang_q[11]);
        endcase
        if (d < -TW'(DEG180)) d = d + TW'(DEG360);
        else if (d > TW'(DEG180)) d = d - TW'(DEG360);
        th_q[t] <= d;
      end
    end
  end

  // divider setup: ratios t2/t1, t1/t2, t1/t3, t2/t4, t7/t5, t8/t6
  div_t dv_q [QB+1][NRAT];
  grd_t grd_q [QB+1];
  div_t dv0_d [NRAT];
  grd_t grd0_d;

  always_comb begin
    logic signed [TW-1:0] nm, dn;
    for (int r = 0; r < NRAT; r++) begin
      case (r)
        0: begin nm = th_q[1]; dn = th_q[0]; end
        1: begin nm = th_q[0]; dn = th_q[1]; end
        2: begin nm = th_q[0]; dn = th_q[2]; end
        3: begin nm = th_q[1]; dn = th_q[3]; end
        4: begin nm = th_q[6]; dn = th_q[4]; end
        default: begin nm = th_q[7]; dn = th_q[5]; end
      endcase
      dv0_d[r].zero = (nm <= 0);
      dv0_d[r].den  = NW'(dn);
      dv0_d[r].r    = RW'(NW'(nm)) << 8;
      dv0_d[r].q    = '0;
      dv0_d[r].full = (dn <= 0) || (RW'(NW'(nm)) >= (RW'(NW'(dn)) << 4));
    end
    grd0_d.g_left  = (th_q[0] <= 0);
    grd0_d.g_right = (th_q[1] <= 0);
    grd0_d.g_up    = (th_q[2] <= TW'(TEN_DEG)) || (th_q[3] <= TW'(TEN_DEG));
    grd0_d.g_down  = (th_q[4] <= TW'(TEN_DEG)) || (th_q[5] <= TW'(TEN_DEG));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0]  <= dv0_d;
      grd_q[0] <= grd0_d;
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int unsigned B = QB - 1 - j;
    div_t dj_d [NRAT];
    always_comb begin
      logic [RW-1:0] sub;
      for (int r = 0; r < NRAT; r++) begin
        dj_d[r] = dv_q[j][r];
        sub = RW'(dv_q[j][r].den) << B;
        if (dv_q[j][r].r >= sub) begin
          dj_d[r].r    = dv_q[j][r].r - sub;
          dj_d[r].q[B] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[j+1]  <= dj_d;
        grd_q[j+1] <= grd_q[j];
      end
    end
  end

  // scores and classification
  logic [SW-1:0] sc [NRAT];
  logic [SW-1:0] left, right, up, down;
  logic [2:0]    cls;
  logic [2:0]    cls_q;
  grd_t          g;
  mid_t          m;

  always_comb begin
    for (int r = 0; r < NRAT; r++) begin
      if (dv_q[QB][r].zero) sc[r] = '0;
      else if (dv_q[QB][r].full) sc[r] = SCORE_MAX;
      else sc[r] = dv_q[QB][r].q;
    end
    g = grd_q[QB];
    m = mid_q[S_LST];
    if (g.g_left) begin
      left  = SCORE_TEN;
      right = '0;
    end else if (g.g_right) begin
      left  = '0;
      right = SCORE_TEN;
    end else begin
      left  = sc[0];
      right = sc[1];
    end
    if (g.g_up) up = SCORE_TEN;
    else up = (sc[2] > sc[3]) ? sc[2] : sc[3];
    if (g.g_down) down = SCORE_TEN;
    else down = (sc[4] > sc[5]) ? sc[4] : sc[5];

    if (left >= strong_q) cls = POSE_LEFT;
    else if (left >= weak_q && m.right_in) cls = POSE_LEFT;
    else if (right >= strong_q) cls = POSE_RIGHT;
    else if (right >= weak_q && m.left_in) cls = POSE_RIGHT;
    else if (up >= UP_LIMIT) cls = POSE_UP;
    else if (down >= DOWN_LIMIT) cls = POSE_DOWN;
    else if (left > slight_q) cls = POSE_SLIGHT_LEFT;
    else if (right > slight_q) cls = POSE_SLIGHT_RIGHT;
    else cls = POSE_FRONTAL;
  end

  always_ff @(posedge clk_i) begin
    if (adv) cls_q <= cls;
  end

  assign m_axis_tdata = {5'b0, cls_q};

endmodule
